// File: sv/dto_pkg.sv
// ----------------------------------------------------------------------------
// dto_pkg
// Shared types, constants and the month-length lookup for the date-time
// offset adder.
// ----------------------------------------------------------------------------
package dto_pkg;

  localparam int unsigned MAX_YEAR = 9999;

  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MIN_W    = 6;
  localparam int unsigned SEC_W    = 6;
  localparam int unsigned DELTA_W  = 15;

  // signed working width for every intermediate count
  localparam int unsigned ACC_W    = 17;

  // constant divider: unsigned dividend magnitude, quotient by reciprocal
  // multiply, then remainder by multiplying back, one step each
  localparam int unsigned DIV_W     = 16;
  localparam int unsigned DIV_CNT_W = 1;
  localparam int unsigned DIVSR_W   = 6;

  // ceil(2^22 / d), exact floor quotient for any 16-bit dividend
  localparam int unsigned RECIP_W   = 19;
  localparam int unsigned RECIP_SH  = 22;
  localparam logic [RECIP_W-1:0] RECIP_60 = 19'd69906;
  localparam logic [RECIP_W-1:0] RECIP_24 = 19'd174763;
  localparam logic [RECIP_W-1:0] RECIP_12 = 19'd349526;

  typedef logic signed [ACC_W-1:0] acc_t;

  localparam logic [YEAR_W-1:0] RESET_YEAR   = 14'd1960;
  localparam logic [YEAR_W-1:0] MAX_YEAR_VAL = YEAR_W'(MAX_YEAR);
  localparam acc_t              MAX_YEAR_ACC = acc_t'(MAX_YEAR);

  localparam logic [DIVSR_W-1:0] SEC_PER_MIN    = 6'd60;
  localparam logic [DIVSR_W-1:0] MIN_PER_HOUR   = 6'd60;
  localparam logic [DIVSR_W-1:0] HOUR_PER_DAY   = 6'd24;
  localparam logic [DIVSR_W-1:0] MONTH_PER_YEAR = 6'd12;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_SUB = 1'b1;

  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic                op;
    logic [YEAR_W-1:0]   delta_years;
    logic [11:0]         delta_months;
    logic [DELTA_W-1:0]  delta_days;
    logic [DELTA_W-1:0]  delta_hours;
    logic [DELTA_W-1:0]  delta_minutes;
    logic [DELTA_W-1:0]  delta_seconds;
  } in_item_t;

  typedef struct packed {
    logic [YEAR_W-1:0]  out_year;
    logic [MONTH_W-1:0] out_month;
    logic [DAY_W-1:0]   out_day;
    logic [HOUR_W-1:0]  out_hour;
    logic [MIN_W-1:0]   out_minute;
    logic [SEC_W-1:0]   out_second;
    logic               range_error;
  } out_item_t;

  typedef struct packed {
    logic               start;
    acc_t               arg;
    logic [DIVSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    acc_t               quo;
    logic [DIVSR_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } core_stat_t;

  // february gets 29 days when the low two year bits are zero
  function automatic logic [DAY_W-1:0] days_of(input logic [MONTH_W-1:0] mo,
                                               input logic [1:0] ylo);
    logic [DAY_W-1:0] n;
    n = MONTH_LEN[0];
    if (mo >= MONTH_JAN && mo <= MONTH_DEC) begin
      n = MONTH_LEN[mo - MONTH_JAN];
    end
    if (mo == MONTH_FEB && ylo == 2'b00) begin
      n = n + DAY_W'(1);
    end
    return n;
  endfunction

endpackage

// File: sv/dto_cdiv.sv
// ----------------------------------------------------------------------------
// dto_cdiv
// Shared divider by a small constant. Quotient by reciprocal multiplication,
// remainder by multiplying back, with floor correction for negative dividends.
// ----------------------------------------------------------------------------
module dto_cdiv (
  input  logic              clk,
  input  logic              rst_n,
  input  dto_pkg::div_req_t req,
  output dto_pkg::div_rsp_t rsp
);
  import dto_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 neg_r;
  logic [DIV_W-1:0]     mag_r;
  logic [DIV_W-1:0]     quo_r;
  logic [DIVSR_W-1:0]   rem_r;
  logic [DIVSR_W-1:0]   dvsr_r;

  logic [RECIP_W-1:0]         recip;
  logic [DIV_W+RECIP_W-1:0]   prod;
  logic [DIV_W+DIVSR_W-1:0]   back;
  logic [DIV_W-1:0]           diff;
  logic [DIV_W-1:0]           mag_in;
  acc_t                       quo_mag;
  logic                       load;

  assign load = req.start && !busy_r;

  always_comb begin
    case (dvsr_r)
      SEC_PER_MIN: begin
        // minutes per hour shares this divisor
        recip = RECIP_60;
      end
      HOUR_PER_DAY: begin
        recip = RECIP_24;
      end
      MONTH_PER_YEAR: begin
        recip = RECIP_12;
      end
      default: begin
        recip = RECIP_60;
      end
    endcase
    prod    = {{RECIP_W{1'b0}}, mag_r} * {{DIV_W{1'b0}}, recip};
    back    = {{DIVSR_W{1'b0}}, quo_r} * {{DIV_W{1'b0}}, dvsr_r};
    diff    = mag_r - back[DIV_W-1:0];
    mag_in  = req.arg[ACC_W-1] ? DIV_W'(-req.arg) : DIV_W'(req.arg);
    quo_mag = $signed({1'b0, quo_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (load) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // first step forms the quotient, second the remainder
  always_ff @(posedge clk) begin
    if (load) begin
      neg_r  <= req.arg[ACC_W-1];
      mag_r  <= mag_in;
      dvsr_r <= req.divisor;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        quo_r <= DIV_W'(prod[DIV_W+RECIP_W-1:RECIP_SH]);
      end else begin
        rem_r <= diff[DIVSR_W-1:0];
      end
    end
  end

  // floor quotient, remainder always in 0..divisor-1
  always_comb begin
    rsp.done = done_r;
    if (!neg_r) begin
      rsp.quo = quo_mag;
      rsp.rem = rem_r;
    end else if (rem_r == '0) begin
      rsp.quo = -quo_mag;
      rsp.rem = '0;
    end else begin
      rsp.quo = -quo_mag - acc_t'(1);
      rsp.rem = dvsr_r - rem_r;
    end
  end

endmodule

// File: sv/dto_core.sv
// ----------------------------------------------------------------------------
// dto_core
// Sequencer and calendar state: time carries through the shared divider,
// then a month-by-month day walk, then the month/year step and saturation.
// ----------------------------------------------------------------------------
module dto_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_take,
  input  dto_pkg::in_item_t   req_data,
  input  logic                res_take,
  output dto_pkg::core_stat_t stat,
  output dto_pkg::out_item_t  res_data
);
  import dto_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SEC  = 7'b0000010,
    ST_MIN  = 7'b0000100,
    ST_HOUR = 7'b0001000,
    ST_WALK = 7'b0010000,
    ST_MON  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  state_t               state_r;

  logic [YEAR_W-1:0]    cur_year_r;
  logic [MONTH_W-1:0]   cur_month_r;
  logic [DAY_W-1:0]     cur_day_r;
  logic [HOUR_W-1:0]    cur_hour_r;
  logic [MIN_W-1:0]     cur_min_r;
  logic [SEC_W-1:0]     cur_sec_r;

  logic                 op_r;
  logic [YEAR_W-1:0]    dy_r;
  logic [11:0]          dm_r;
  logic [DELTA_W-1:0]   dd_r;
  logic [DELTA_W-1:0]   dh_r;
  logic [DELTA_W-1:0]   dmi_r;

  acc_t                 y_r;
  logic [MONTH_W-1:0]   mo_r;
  acc_t                 d_r;
  logic [HOUR_W-1:0]    h_r;
  logic [MIN_W-1:0]     mi_r;
  logic [SEC_W-1:0]     s_r;

  div_req_t             div_req;
  div_rsp_t             div_rsp;

  logic [MONTH_W-1:0]   mo_dec;
  acc_t                 y_dec;
  logic [DAY_W-1:0]     days_dec;
  logic [DAY_W-1:0]     days_cur;
  logic                 d_low;
  logic                 d_high;
  logic                 y_neg;
  logic                 y_over;
  logic [YEAR_W-1:0]    sat_year;

  function automatic acc_t apply_delta(input acc_t base, input logic [DELTA_W-1:0] delta,
                                       input logic op);
    acc_t dx;
    dx = $signed({{(ACC_W-DELTA_W){1'b0}}, delta});
    return (op == OP_SUB) ? base - dx : base + dx;
  endfunction

  dto_cdiv u_cdiv (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  // day walk helpers
  always_comb begin
    mo_dec   = (mo_r == MONTH_JAN) ? MONTH_DEC : mo_r - MONTH_W'(1);
    y_dec    = (mo_r == MONTH_JAN) ? y_r - acc_t'(1) : y_r;
    days_dec = days_of(mo_dec, y_dec[1:0]);
    days_cur = days_of(mo_r, y_r[1:0]);
    d_low    = d_r[ACC_W-1] || (d_r == '0);
    d_high   = d_r > $signed({{(ACC_W-DAY_W){1'b0}}, days_cur});
  end

  always_comb begin
    div_req.start   = 1'b0;
    div_req.arg     = '0;
    div_req.divisor = SEC_PER_MIN;
    case (state_r)
      ST_IDLE: begin
        div_req.start = req_take;
        div_req.arg   = apply_delta($signed({{(ACC_W-SEC_W){1'b0}}, cur_sec_r}),
                                    req_data.delta_seconds, req_data.op);
      end
      ST_SEC: begin
        div_req.start   = div_rsp.done;
        div_req.arg     = apply_delta($signed({{(ACC_W-MIN_W){1'b0}}, cur_min_r}),
                                      dmi_r, op_r) + div_rsp.quo;
        div_req.divisor = MIN_PER_HOUR;
      end
      ST_MIN: begin
        div_req.start   = div_rsp.done;
        div_req.arg     = apply_delta($signed({{(ACC_W-HOUR_W){1'b0}}, cur_hour_r}),
                                      dh_r, op_r) + div_rsp.quo;
        div_req.divisor = HOUR_PER_DAY;
      end
      ST_WALK: begin
        div_req.start   = !d_low && !d_high;
        div_req.arg     = apply_delta($signed({{(ACC_W-MONTH_W){1'b0}}, mo_r}) - acc_t'(1),
                                      {3'b000, dm_r}, op_r);
        div_req.divisor = MONTH_PER_YEAR;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  // year saturation
  always_comb begin
    y_neg    = y_r[ACC_W-1];
    y_over   = !y_neg && (y_r > MAX_YEAR_ACC);
    sat_year = y_neg ? '0 : (y_over ? MAX_YEAR_VAL : y_r[YEAR_W-1:0]);
  end

  always_comb begin
    res_data.out_year    = sat_year;
    res_data.out_month   = mo_r;
    res_data.out_day     = d_r[DAY_W-1:0];
    res_data.out_hour    = h_r;
    res_data.out_minute  = mi_r;
    res_data.out_second  = s_r;
    res_data.range_error = y_neg || y_over;
    stat.idle            = (state_r == ST_IDLE);
    stat.res_valid       = (state_r == ST_DONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_year_r  <= RESET_YEAR;
      cur_month_r <= MONTH_JAN;
      cur_day_r   <= DAY_W'(1);
      cur_hour_r  <= '0;
      cur_min_r   <= '0;
      cur_sec_r   <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (req_take) begin
            state_r <= ST_SEC;
          end
        end
        ST_SEC: begin
          if (div_rsp.done) begin
            state_r <= ST_MIN;
          end
        end
        ST_MIN: begin
          if (div_rsp.done) begin
            state_r <= ST_HOUR;
          end
        end
        ST_HOUR: begin
          if (div_rsp.done) begin
            state_r <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (!d_low && !d_high) begin
            state_r <= ST_MON;
          end
        end
        ST_MON: begin
          if (div_rsp.done) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_take) begin
            state_r     <= ST_IDLE;
            cur_year_r  <= sat_year;
            cur_month_r <= mo_r;
            cur_day_r   <= d_r[DAY_W-1:0];
            cur_hour_r  <= h_r;
            cur_min_r   <= mi_r;
            cur_sec_r   <= s_r;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (req_take) begin
          op_r  <= req_data.op;
          dy_r  <= req_data.delta_years;
          dm_r  <= req_data.delta_months;
          dd_r  <= req_data.delta_days;
          dh_r  <= req_data.delta_hours;
          dmi_r <= req_data.delta_minutes;
          y_r   <= $signed({{(ACC_W-YEAR_W){1'b0}}, cur_year_r});
          mo_r  <= (cur_month_r >= MONTH_JAN && cur_month_r <= MONTH_DEC) ?
                   cur_month_r : MONTH_JAN;
        end
      end
      ST_SEC: begin
        if (div_rsp.done) begin
          s_r <= div_rsp.rem;
        end
      end
      ST_MIN: begin
        if (div_rsp.done) begin
          mi_r <= div_rsp.rem;
        end
      end
      ST_HOUR: begin
        if (div_rsp.done) begin
          h_r <= div_rsp.rem[HOUR_W-1:0];
          d_r <= apply_delta($signed({{(ACC_W-DAY_W){1'b0}}, cur_day_r}), dd_r, op_r)
                 + div_rsp.quo;
        end
      end
      ST_WALK: begin
        if (d_low) begin
          // borrow the previous month
          mo_r <= mo_dec;
          y_r  <= y_dec;
          d_r  <= d_r + $signed({{(ACC_W-DAY_W){1'b0}}, days_dec});
        end else if (d_high) begin
          d_r <= d_r - $signed({{(ACC_W-DAY_W){1'b0}}, days_cur});
          if (mo_r == MONTH_DEC) begin
            mo_r <= MONTH_JAN;
            y_r  <= y_r + acc_t'(1);
          end else begin
            mo_r <= mo_r + MONTH_W'(1);
          end
        end else begin
          y_r <= apply_delta(y_r, {1'b0, dy_r}, op_r);
        end
      end
      ST_MON: begin
        if (div_rsp.done) begin
          mo_r <= div_rsp.rem[MONTH_W-1:0] + MONTH_JAN;
          y_r  <= y_r + div_rsp.quo;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: sv/date_time_offset_adder.sv
// ----------------------------------------------------------------------------
// date_time_offset_adder
// Sequence: divider passes for seconds, minutes and hours, then a
//   month-by-month day walk (up to about 1125 months crossed), then a
//   divider pass for months with the year step: four divider passes in all.
// Throughput: one request at a time; in_stall stays high until the core is idle.
// A finished result sits in the output register while the next request runs.
// Reset (rst_n low, synchronous) sets the date-time to 1960-01-01 00:00:00.
// ----------------------------------------------------------------------------
module date_time_offset_adder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dto_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dto_pkg::out_item_t out_data
);
  import dto_pkg::*;

  core_stat_t stat;
  out_item_t  res_data;
  logic       req_take;
  logic       out_free;
  logic       out_valid_r;
  out_item_t  out_data_r;

  assign in_stall = !stat.idle;
  assign req_take = in_valid && stat.idle;
  assign out_free = !out_valid_r || !out_stall;

  dto_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_take (req_take),
    .req_data (in_data),
    .res_take (out_free),
    .stat     (stat),
    .res_data (res_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.res_valid && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.res_valid && out_free) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sv/dto_chk.sv
// ----------------------------------------------------------------------------
// dto_chk
// Port-level checks for the date-time offset adder, bound to the top level.
// ----------------------------------------------------------------------------
module dto_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input dto_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input dto_pkg::out_item_t out_data
);
  import dto_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && !in_stall && (in_data.op == OP_ADD || in_data.op == OP_SUB);

  // a pending result is never dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("request accepted while busy");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !in_stall && !out_valid)
    else $error("not idle after reset");

  a_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.out_month >= MONTH_JAN && out_data.out_month <= MONTH_DEC &&
                  out_data.out_day != '0 && out_data.out_hour < HOUR_W'(24) &&
                  out_data.out_minute < MIN_W'(60) && out_data.out_second < SEC_W'(60) &&
                  out_data.out_year <= MAX_YEAR_VAL)
    else $error("result field out of range");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.range_error |->
      out_data.out_year == '0 || out_data.out_year == MAX_YEAR_VAL)
    else $error("range error without saturated year");

endmodule

bind date_time_offset_adder dto_chk u_dto_chk (.*);
